// ===== hw/rtl/ibl_pkg.sv =====
// types, phase codes and constants shared by the basicList parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ibl_pkg;

   localparam logic [2:0] PH_HDR    = 3'd0;
   localparam logic [2:0] PH_PREFIX = 3'd1;
   localparam logic [2:0] PH_ESC_HI = 3'd2;
   localparam logic [2:0] PH_ESC_LO = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_ERR    = 3'd5;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PREFIX  = 2'd1;
   localparam logic [1:0] KIND_DATA    = 2'd2;
   localparam logic [1:0] KIND_DISCARD = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_HDR_SHORT   = 3'd1;
   localparam logic [2:0] ST_ZERO_LEN    = 3'd2;
   localparam logic [2:0] ST_PREFIX_TRUNC = 3'd3;
   localparam logic [2:0] ST_MEMBER_TRUNC = 3'd4;

   localparam logic [15:0] VAR_LEN   = 16'hFFFF;
   localparam logic [15:0] ENT_BIT   = 16'h8000;
   localparam logic [7:0]  ESCAPE    = 8'hFF;
   localparam logic [7:0]  SEM_UNDEF = 8'hFF;
   localparam logic [7:0]  SEM_MAX   = 8'd4;
   localparam logic [3:0]  HC_MAX    = 4'd15;
   localparam logic [4:0]  HLEN_BASE = 5'd5;
   localparam logic [4:0]  HLEN_ENT  = 5'd9;

   localparam int TDATA_W = 120;

   typedef struct packed {
      logic [2:0]  phase;
      logic [3:0]  header_count;
      logic [7:0]  semantic;
      logic [15:0] id;
      logic [15:0] length;
      logic [31:0] enterprise;
      logic [15:0] prefix_accum;
      logic [15:0] bytes_left;
      logic [15:0] index;
      logic [2:0]  error;
   } state_type;

   typedef struct packed {
      logic [1:0]  byte_kind;
      logic [7:0]  out_byte;
      logic [15:0] member_index;
      logic [15:0] member_size;
      logic        member_end;
      logic [2:0]  status;
      logic        list_done;
      logic [7:0]  semantic;
      logic [14:0] elem_id;
      logic [31:0] ent_number;
      logic [15:0] declared_length;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_HDR, header_count: 4'd0, semantic: SEM_UNDEF, id: 16'd0,
      length: 16'd0, enterprise: 32'd0, prefix_accum: 16'd0,
      bytes_left: 16'd0, index: 16'd0, error: ST_OK};

endpackage

`default_nettype wire

// ===== hw/rtl/ibl_step.sv =====
// next-state and result logic for one byte of a basicList field
// depends on ibl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ibl_step
   import ibl_pkg::*;
(
   input  wire state_type  cur,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output state_type       nxt,
   output result_type      res
);

   always_comb begin
      state_type  s;
      logic [1:0] kind;
      logic [2:0] st;
      logic       done;
      logic       hdr_more;
      logic       complete;
      logic [4:0] hlen;

      s        = cur;
      kind     = KIND_HEADER;
      st       = ST_OK;
      done     = 1'b0;
      hdr_more = 1'b0;
      complete = 1'b0;
      hlen     = HLEN_BASE;

      unique case (cur.phase)
         PH_HDR: begin
            kind = KIND_HEADER;
            if (cur.header_count == 4'd0) begin
               s.id           = 16'd0;
               s.length       = 16'd0;
               s.enterprise   = 32'd0;
               s.index        = 16'd0;
               s.prefix_accum = 16'd0;
               s.bytes_left   = 16'd0;
               s.error        = ST_OK;
            end
            unique case (cur.header_count)
               4'd0: s.semantic = (data_byte <= SEM_MAX) ? data_byte : SEM_UNDEF;
               4'd1: s.id = {data_byte, 8'd0};
               4'd2: s.id = s.id | {8'd0, data_byte};
               4'd3: s.length = {data_byte, 8'd0};
               4'd4: s.length = s.length | {8'd0, data_byte};
               default: s.enterprise = {s.enterprise[23:0], data_byte};
            endcase
            if (cur.header_count >= 4'd4) begin
               hlen     = ((s.id & ENT_BIT) != 16'd0) ? HLEN_ENT : HLEN_BASE;
               complete = ({1'b0, cur.header_count} + 5'd1) >= hlen;
            end
            if (cur.header_count < HC_MAX) begin
               s.header_count = cur.header_count + 4'd1;
            end
            if (complete) begin
               if (!last_byte) begin
                  if (s.length == 16'd0) begin
                     st      = ST_ZERO_LEN;
                     s.error = ST_ZERO_LEN;
                     s.phase = PH_ERR;
                  end else begin
                     hdr_more = 1'b1;
                  end
               end
            end else if (last_byte) begin
               st = ST_HDR_SHORT;
            end
         end
         PH_PREFIX: begin
            kind = KIND_PREFIX;
            if (data_byte != ESCAPE) begin
               s.prefix_accum = {8'd0, data_byte};
               s.bytes_left   = {8'd0, data_byte};
               priority if (data_byte == 8'd0) done = 1'b1;
               else if (last_byte) st = ST_MEMBER_TRUNC;
               else s.phase = PH_DATA;
            end else begin
               s.prefix_accum = 16'd0;
               if (last_byte) st = ST_PREFIX_TRUNC;
               else s.phase = PH_ESC_HI;
            end
         end
         PH_ESC_HI: begin
            kind = KIND_PREFIX;
            s.bytes_left = {data_byte, 8'd0};
            if (last_byte) st = ST_PREFIX_TRUNC;
            else s.phase = PH_ESC_LO;
         end
         PH_ESC_LO: begin
            kind = KIND_PREFIX;
            s.bytes_left   = cur.bytes_left | {8'd0, data_byte};
            s.prefix_accum = s.bytes_left;
            priority if (s.bytes_left == 16'd0) done = 1'b1;
            else if (last_byte) st = ST_MEMBER_TRUNC;
            else s.phase = PH_DATA;
         end
         PH_DATA: begin
            kind = KIND_DATA;
            if (cur.bytes_left != 16'd0) s.bytes_left = cur.bytes_left - 16'd1;
            if (s.bytes_left == 16'd0) done = 1'b1;
            else if (last_byte) st = ST_MEMBER_TRUNC;
         end
         default: begin
            kind = KIND_DISCARD;
            st   = cur.error;
         end
      endcase

      res.byte_kind       = kind;
      res.out_byte        = data_byte;
      res.member_index    = s.index;
      res.member_size     = s.prefix_accum;
      res.member_end      = done;
      res.status          = st;
      res.list_done       = last_byte;
      res.semantic        = s.semantic;
      res.elem_id         = s.id[14:0];
      res.ent_number      = s.enterprise;
      res.declared_length = s.length;

      if (done && s.index != 16'hFFFF) s.index = s.index + 16'd1;
      if (done || hdr_more) begin
         if (s.length == VAR_LEN) begin
            s.phase        = PH_PREFIX;
            s.prefix_accum = 16'd0;
            s.bytes_left   = 16'd0;
         end else begin
            s.phase        = PH_DATA;
            s.prefix_accum = s.length;
            s.bytes_left   = s.length;
         end
      end
      if (last_byte) begin
         s.phase        = PH_HDR;
         s.header_count = 4'd0;
         s.error        = ST_OK;
      end
      nxt = s;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ipfix_basic_list_parser.sv =====
// top level of the ipfix basicList parser: parse state and output register
// depends on ibl_pkg and ibl_step
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of a basicList field per beat and returns one tagged beat per
// byte, in order. Each byte is handled by combinational parse logic between the
// state register and the output register, so a byte can be taken in every
// cycle unless the input stalls; throughput is then one byte per clock. The
// output register lets the next byte in as its held result is taken, and the
// input stalls only when a result is held and rsp_tready is low. The list
// ends on a beat with req_tlast set, and parsing restarts at the header.

module ipfix_basic_list_parser
   import ibl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,  // data_byte
   input  wire logic         req_tlast,  // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_byte, member_index, member_size, member_end, status, semantic,
   // elem_id, ent_number, declared_length, zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic [1:0]        rsp_tuser,  // byte_kind
   output logic              rsp_tlast   // list_done
);

   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       valid_ff, valid_in;
   logic       accept;

   ibl_step u_step (
      .cur       (state_ff),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .nxt       (state_in),
      .res       (res_in)
   );

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (accept) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.byte_kind;
   assign rsp_tlast  = res_ff.list_done;
   assign rsp_tdata  = {5'd0, res_ff.declared_length, res_ff.ent_number,
                        res_ff.elem_id, res_ff.semantic, res_ff.status,
                        res_ff.member_end, res_ff.member_size, res_ff.member_index,
                        res_ff.out_byte};

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the ipfix basicList parser: a directed table, then random lists,
// every result beat checked field by field against a behavioral parser
// depends on ibl_pkg and ipfix_basic_list_parser
`timescale 1ns / 1ps

module testbench;
   import ibl_pkg::*;

   localparam int RANDOM_BEATS = 1250;
   localparam int HOLD_CYCLES  = 300;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC
   } ready_mode_type;

   typedef struct packed {
      logic [7:0] b;
      logic       l;
      logic       pinned;
      logic [1:0] kind;
      logic [2:0] code;
   } step_row_type;

   typedef struct {
      result_type tag;
      bit         pinned;
      logic [1:0] pin_kind;
      logic [2:0] pin_status;
   } byte_tag_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;

   state_type parse_state;
   byte_tag_type tags_due [$];
   step_row_type steps [26];
   int mismatch_count = 0;
   int beats_sent = 0;
   int burst_left = 0;

   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mode_left = 0;
   ready_mode_type stall_mode = READY_ALWAYS;
   logic [15:0] cycle_count = 16'd0;

   ipfix_basic_list_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

   function automatic void open_member();
      if (parse_state.length == VAR_LEN) begin
         parse_state.phase = PH_PREFIX;
         parse_state.prefix_accum = 16'd0;
         parse_state.bytes_left = 16'd0;
      end else begin
         parse_state.phase = PH_DATA;
         parse_state.prefix_accum = parse_state.length;
         parse_state.bytes_left = parse_state.length;
      end
   endfunction

   task automatic tag_byte(input logic [7:0] b, input logic l, output result_type r);
      logic [4:0] hdr_len;
      logic complete;
      logic member_done;
      logic hdr_more;
      logic [1:0] kind;
      logic [2:0] code;
      complete = 1'b0;
      member_done = 1'b0;
      hdr_more = 1'b0;
      kind = KIND_HEADER;
      code = ST_OK;
      case (parse_state.phase)
         PH_HDR: begin
            if (parse_state.header_count == 4'd0) begin
               parse_state.id = 16'd0;
               parse_state.length = 16'd0;
               parse_state.enterprise = 32'd0;
               parse_state.index = 16'd0;
               parse_state.prefix_accum = 16'd0;
               parse_state.bytes_left = 16'd0;
               parse_state.error = ST_OK;
            end
            case (parse_state.header_count)
               4'd0: parse_state.semantic = (b <= SEM_MAX) ? b : SEM_UNDEF;
               4'd1: parse_state.id = {b, 8'h00};
               4'd2: parse_state.id[7:0] = b;
               4'd3: parse_state.length = {b, 8'h00};
               4'd4: parse_state.length[7:0] = b;
               default: parse_state.enterprise = {parse_state.enterprise[23:0], b};
            endcase
            if (parse_state.header_count >= 4'd4) begin
               hdr_len = ((parse_state.id & ENT_BIT) != 16'd0) ? HLEN_ENT : HLEN_BASE;
               complete = ({1'b0, parse_state.header_count} + 5'd1) >= hdr_len;
            end
            if (parse_state.header_count < HC_MAX)
               parse_state.header_count = parse_state.header_count + 4'd1;
            if (complete) begin
               if (!l) begin
                  if (parse_state.length == 16'd0) begin
                     code = ST_ZERO_LEN;
                     parse_state.error = ST_ZERO_LEN;
                     parse_state.phase = PH_ERR;
                  end else begin
                     hdr_more = 1'b1;
                  end
               end
            end else if (l) begin
               code = ST_HDR_SHORT;
            end
         end
         PH_PREFIX: begin
            kind = KIND_PREFIX;
            if (b != ESCAPE) begin
               parse_state.prefix_accum = {8'h00, b};
               parse_state.bytes_left = {8'h00, b};
               if (b == 8'd0) member_done = 1'b1;
               else if (l) code = ST_MEMBER_TRUNC;
               else parse_state.phase = PH_DATA;
            end else begin
               parse_state.prefix_accum = 16'd0;
               if (l) code = ST_PREFIX_TRUNC;
               else parse_state.phase = PH_ESC_HI;
            end
         end
         PH_ESC_HI: begin
            kind = KIND_PREFIX;
            parse_state.bytes_left = {b, 8'h00};
            if (l) code = ST_PREFIX_TRUNC;
            else parse_state.phase = PH_ESC_LO;
         end
         PH_ESC_LO: begin
            kind = KIND_PREFIX;
            parse_state.bytes_left[7:0] = b;
            parse_state.prefix_accum = parse_state.bytes_left;
            if (parse_state.bytes_left == 16'd0) member_done = 1'b1;
            else if (l) code = ST_MEMBER_TRUNC;
            else parse_state.phase = PH_DATA;
         end
         PH_DATA: begin
            kind = KIND_DATA;
            if (parse_state.bytes_left != 16'd0)
               parse_state.bytes_left = parse_state.bytes_left - 16'd1;
            if (parse_state.bytes_left == 16'd0) member_done = 1'b1;
            else if (l) code = ST_MEMBER_TRUNC;
         end
         default: begin
            kind = KIND_DISCARD;
            code = parse_state.error;
         end
      endcase

      r.byte_kind = kind;
      r.out_byte = b;
      r.member_index = parse_state.index;
      r.member_size = parse_state.prefix_accum;
      r.member_end = member_done;
      r.status = code;
      r.list_done = l;
      r.semantic = parse_state.semantic;
      r.elem_id = parse_state.id[14:0];
      r.ent_number = parse_state.enterprise;
      r.declared_length = parse_state.length;

      if (member_done) begin
         if (parse_state.index != 16'hFFFF) parse_state.index = parse_state.index + 16'd1;
         open_member();
      end else if (hdr_more) begin
         open_member();
      end
      if (l) begin
         parse_state.phase = PH_HDR;
         parse_state.header_count = 4'd0;
         parse_state.error = ST_OK;
      end
   endtask

   task automatic send_beat(input logic [7:0] b, input logic l, input bit pinned = 1'b0,
                            input logic [1:0] pin_kind = KIND_HEADER,
                            input logic [2:0] pin_status = ST_OK);
      logic took;
      byte_tag_type entry;
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 8);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      tag_byte(b, l, entry.tag);
      entry.pinned = pinned;
      entry.pin_kind = pin_kind;
      entry.pin_status = pin_status;
      tags_due.push_back(entry);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tags_due.size() != 0);
      burst_left = 0;
   endtask

   task automatic send_random_list();
      logic [7:0] body [$];
      logic [15:0] id;
      logic [15:0] elen;
      logic [15:0] msize;
      logic big;
      int members;
      int cut;
      int pick;
      body = {};
      big = 1'b0;
      if ($urandom_range(0, 15) == 0) begin
         repeat ($urandom_range(1, 12)) send_beat(8'($urandom), $urandom_range(0, 5) == 0);
         send_beat(8'($urandom), 1'b1);
         return;
      end
      body.push_back(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom));
      id = 16'($urandom);
      id[15] = ($urandom_range(0, 2) == 0);
      body.push_back(id[15:8]);
      body.push_back(id[7:0]);
      pick = $urandom_range(0, 9);
      if (pick < 5) elen = VAR_LEN;
      else if (pick < 8) elen = 16'($urandom_range(1, 8));
      else if (pick == 8) elen = 16'd0;
      else begin
         elen = 16'($urandom);
         big = 1'b1;
      end
      body.push_back(elen[15:8]);
      body.push_back(elen[7:0]);
      if (id[15]) repeat (4) body.push_back(8'($urandom));
      members = $urandom_range(0, 5);
      if (big || elen == 16'd0) begin
         repeat (big ? 12 : members) body.push_back(8'($urandom));
      end else if (elen != VAR_LEN) begin
         repeat (members * int'(elen)) body.push_back(8'($urandom));
      end else begin
         for (int m = 0; m < members && !big; m++) begin
            pick = $urandom_range(0, 31);
            if (pick == 0) begin
               msize = 16'd254;
               body.push_back(msize[7:0]);
            end else if (pick < 20) begin
               msize = 16'($urandom_range(0, 6));
               body.push_back(msize[7:0]);
            end else begin
               msize = (pick < 30) ? 16'($urandom_range(0, 6)) : 16'($urandom);
               body.push_back(ESCAPE);
               body.push_back(msize[15:8]);
               body.push_back(msize[7:0]);
               if (pick >= 30) begin
                  msize = 16'd8;
                  big = 1'b1;
               end
            end
            repeat (int'(msize)) body.push_back(8'($urandom));
         end
      end
      cut = (big || $urandom_range(0, 4) == 0) ? $urandom_range(1, body.size()) : body.size();
      for (int k = 0; k < cut; k++) send_beat(body[k], k == cut - 1);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         if (mismatch_count <= 40)
            $display("%0t %s expected %0h actual %0h", $time, name, want, seen);
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 16'd1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= ready_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 250);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN: rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cycle_count[3];
         endcase
      end
   end

   always @(negedge clock) begin
      byte_tag_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tags_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 40)
               $display("%0t unexpected beat, expected none actual %h", $time, rsp_tdata);
         end else begin
            due = tags_due.pop_front();
            check_field("byte_kind", due.tag.byte_kind, rsp_tuser);
            check_field("out_byte", due.tag.out_byte, rsp_tdata[7:0]);
            check_field("member_index", due.tag.member_index, rsp_tdata[23:8]);
            check_field("member_size", due.tag.member_size, rsp_tdata[39:24]);
            check_field("member_end", due.tag.member_end, rsp_tdata[40]);
            check_field("status", due.tag.status, rsp_tdata[43:41]);
            check_field("list_done", due.tag.list_done, rsp_tlast);
            check_field("semantic", due.tag.semantic, rsp_tdata[51:44]);
            check_field("elem_id", due.tag.elem_id, rsp_tdata[66:52]);
            check_field("ent_number", due.tag.ent_number, rsp_tdata[98:67]);
            check_field("declared_length", due.tag.declared_length, rsp_tdata[114:99]);
            check_field("tdata fill", 32'd0, rsp_tdata[TDATA_W-1:115]);
            if (due.pinned) begin
               check_field("table byte_kind", due.pin_kind, rsp_tuser);
               check_field("table status", due.pin_status, rsp_tdata[43:41]);
            end
         end
      end
   end

   initial begin
      int lists;
      steps = '{
         // short header
         '{8'h00, 1'b0, 1'b1, KIND_HEADER, ST_OK},
         '{8'h12, 1'b1, 1'b1, KIND_HEADER, ST_HDR_SHORT},
         // empty list with zero element length
         '{8'h04, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h01, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b1, 1'b1, KIND_HEADER, ST_OK},
         // zero element length with more bytes, undefined semantic
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h7F, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b0, 1'b1, KIND_HEADER, ST_ZERO_LEN},
         '{8'hAB, 1'b0, 1'b1, KIND_DISCARD, ST_ZERO_LEN},
         '{8'h55, 1'b1, 1'b1, KIND_DISCARD, ST_ZERO_LEN},
         // enterprise header, variable length, zero prefix, escape cut short
         '{8'h05, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h80, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h05, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b0, 1'b1, KIND_PREFIX, ST_OK},
         '{8'hFF, 1'b0, 1'b0, KIND_HEADER, ST_OK},
         '{8'h00, 1'b1, 1'b1, KIND_PREFIX, ST_PREFIX_TRUNC}
      };
      parse_state = STATE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < $size(steps); i++)
         send_beat(steps[i].b, steps[i].l, steps[i].pinned, steps[i].kind, steps[i].code);
      drain_results();
      lists = 0;
      while (beats_sent < $size(steps) + RANDOM_BEATS) begin
         send_random_list();
         lists++;
         if (lists % 60 == 20) hold_asks <= hold_asks + 1;
         if (lists % 60 == 45) drain_results();
      end
      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
